/* sv/lptt_pkg.sv */
// lptt_pkg: shared types and constants for the LRU page translation table.
// No dependencies; used by the top module and the match and recency cells by scoped names.

package lptt_pkg;

    // Fixed field widths of the stream items
    localparam int ADDR_W  = 48;
    localparam int UPAGE_W = 36;
    localparam int FUNC_W  = 2;

    // Padded stream widths
    localparam int IN_DATA_W  = 136;
    localparam int OUT_DATA_W = 48;
    localparam int OUT_USER_W = 2;

    // Operation codes carried in the input tuser
    typedef enum logic [FUNC_W-1:0] {
        FN_TRANSLATE = 2'd0,
        FN_MAP       = 2'd1,
        FN_UNMAP     = 2'd2
    } func_t;

    // Sequencer states
    typedef enum logic [1:0] {
        S_IDLE,
        S_LOOK,
        S_LOCATE,
        S_UPDATE
    } state_t;

    // Write controls broadcast to the match cells
    typedef struct packed {
        logic write;    // load page and set mapped at the selected slot
        logic clear;    // clear mapped at the selected slot
    } cam_ctl_t;

    // Controls broadcast to the recency cells
    typedef struct packed {
        logic move;     // remove the slot from its position and put it last
        logic append;   // put the slot at the first unused position
    } ord_ctl_t;

endpackage

/* sv/lru_page_translation_table.sv */
// Fully associative page translation table with least-recently-used replacement.
// An operation (tuser: 0 translate, 1 map, 2 unmap) is taken when the block is
// idle and yields one result transfer. Each operation passes through the steps
// (accept, associative page match, position search in the recency chain,
// update). Its result is registered when the update commits, and the next
// operation can be taken in the cycle after the update, so the block takes no
// new operation while one is in progress. The update waits while the output
// register still holds a result that m_axis_tready has not taken.
// The result register lets the next operation enter while a result is pending.
// PAGE_BYTES must be a power of two. Translate returns {frame, offset}; map
// reports evicted when the least recent slot was overwritten.
// Depends on lptt_pkg, lptt_cam_cell, lptt_order_cell, lptt_onehot_enc.

module lru_page_translation_table #(
    parameter int ENTRIES    = 64,
    parameter int PAGE_BYTES = 4096
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // virt_address[47:0], phys_address_in[95:48], unmap_page[131:96], zero pad
    input  logic [lptt_pkg::IN_DATA_W-1:0]    s_axis_tdata,
    // func[1:0]
    input  logic [lptt_pkg::FUNC_W-1:0]       s_axis_tuser,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // phys_address_out[47:0]
    output logic [lptt_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
    // hit[0], evicted[1]
    output logic [lptt_pkg::OUT_USER_W-1:0]   m_axis_tuser
);

    localparam int ADDR_W = lptt_pkg::ADDR_W;
    localparam int OFS_W  = $clog2(PAGE_BYTES);
    localparam int PW     = ADDR_W - OFS_W;
    localparam int KW     = (PW > lptt_pkg::UPAGE_W) ? PW : lptt_pkg::UPAGE_W;
    localparam int SLOT_W = $clog2(ENTRIES);
    localparam int CNT_W  = $clog2(ENTRIES + 1);

    // Input field split
    logic [ADDR_W-1:0]            in_virt;
    logic [ADDR_W-1:0]            in_phys;
    logic [lptt_pkg::UPAGE_W-1:0] in_upage;
    lptt_pkg::func_t              in_func;
    logic [KW-1:0]                key_wide;

    assign in_virt  = s_axis_tdata[ADDR_W-1:0];
    assign in_phys  = s_axis_tdata[2*ADDR_W-1:ADDR_W];
    assign in_upage = s_axis_tdata[2*ADDR_W+lptt_pkg::UPAGE_W-1:2*ADDR_W];
    assign in_func  = lptt_pkg::func_t'(s_axis_tuser);

    // Search key: unmap page or page of the virtual address
    assign key_wide = (in_func == lptt_pkg::FN_UNMAP) ? KW'(in_upage)
                                                      : KW'(in_virt[ADDR_W-1:OFS_W]);

    // Sequencer and operation registers
    lptt_pkg::state_t  state_reg, state_next;
    lptt_pkg::func_t   func_reg;
    logic [PW-1:0]     page_reg;
    logic [OFS_W-1:0]  offset_reg;
    logic [PW-1:0]     frame_in_reg;
    logic [PW-1:0]     key_reg;
    logic              key_ok_reg;
    logic              found_reg;
    logic [SLOT_W-1:0] slot_reg;
    logic [SLOT_W-1:0] pos_reg;
    logic [CNT_W-1:0]  fill_reg;
    logic [PW-1:0]     frame_rd_reg;

    logic                        m_valid_reg;
    logic [ADDR_W-1:0]           m_data_reg;
    logic [lptt_pkg::OUT_USER_W-1:0] m_user_reg;

    logic accept;
    logic out_free;
    logic commit;

    assign accept   = s_axis_tvalid && s_axis_tready;
    assign out_free = !m_valid_reg || m_axis_tready;
    assign commit   = (state_reg == lptt_pkg::S_UPDATE) && out_free;

    assign s_axis_tready = (state_reg == lptt_pkg::S_IDLE);

    // Operation decode for the update step
    logic full;
    logic is_tr;
    logic is_map;
    logic is_un;
    logic tr_hit;
    logic map_evict;
    logic map_fill;
    logic un_hit;

    assign full      = fill_reg == CNT_W'(ENTRIES);
    assign is_tr     = func_reg == lptt_pkg::FN_TRANSLATE;
    assign is_map    = func_reg == lptt_pkg::FN_MAP;
    assign is_un     = func_reg == lptt_pkg::FN_UNMAP;
    assign tr_hit    = is_tr && found_reg;
    assign map_evict = is_map && !found_reg && full;
    assign map_fill  = is_map && !found_reg && !full;
    assign un_hit    = is_un && found_reg;

    lptt_pkg::cam_ctl_t cam_ctl;
    lptt_pkg::ord_ctl_t ord_ctl;

    always_comb
    begin
        cam_ctl.write  = commit && (map_evict || map_fill);
        cam_ctl.clear  = commit && un_hit;
        ord_ctl.move   = commit && (tr_hit || (is_map && found_reg) || map_evict);
        ord_ctl.append = commit && map_fill;
    end

    // Associative match cells, one per slot
    logic [ENTRIES-1:0] cam_match;
    logic [SLOT_W-1:0]  cam_slot;

    for (genvar i = 0; i < ENTRIES; i++)
    begin : g_cam
        lptt_cam_cell #(
            .PW     (PW),
            .SLOT_W (SLOT_W),
            .IDX    (i)
        ) u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .ctl     (cam_ctl),
            .slot    (slot_reg),
            .wr_page (page_reg),
            .key     (key_reg),
            .match   (cam_match[i])
        );
    end

    lptt_onehot_enc #(
        .N (ENTRIES),
        .W (SLOT_W)
    ) u_cam_enc (
        .onehot (cam_match),
        .idx    (cam_slot)
    );

    // Recency chain, least recent at position 0
    logic [SLOT_W-1:0]  ord_id   [ENTRIES];
    logic [SLOT_W-1:0]  ord_next [ENTRIES];
    logic [ENTRIES-1:0] ord_match;
    logic [SLOT_W-1:0]  ord_pos;

    for (genvar i = 0; i < ENTRIES; i++)
    begin : g_ord
        if (i == ENTRIES - 1)
        begin : g_top
            assign ord_next[i] = slot_reg;
        end
        else
        begin : g_mid
            assign ord_next[i] = ord_id[i+1];
        end

        lptt_order_cell #(
            .SLOT_W (SLOT_W),
            .CNT_W  (CNT_W),
            .IDX    (i)
        ) u_cell (
            .clk     (clk),
            .ctl     (ord_ctl),
            .fill    (fill_reg),
            .pos     (pos_reg),
            .slot    (slot_reg),
            .next_id (ord_next[i]),
            .id      (ord_id[i]),
            .match   (ord_match[i])
        );
    end

    lptt_onehot_enc #(
        .N (ENTRIES),
        .W (SLOT_W)
    ) u_ord_enc (
        .onehot (ord_match),
        .idx    (ord_pos)
    );

    // Target slot: the match, else the least recent when full, else the next free
    logic              look_found;
    logic [SLOT_W-1:0] look_slot;

    always_comb
    begin
        look_found = key_ok_reg && (|cam_match);
        if (look_found)
        begin
            look_slot = cam_slot;
        end
        else if (full)
        begin
            look_slot = ord_id[0];
        end
        else
        begin
            look_slot = fill_reg[SLOT_W-1:0];
        end
    end

    // Frame memory, registered read at the target slot
    logic [PW-1:0] frame_mem [ENTRIES];

    always_ff @(posedge clk)
    begin
        if (commit && is_map)
        begin
            frame_mem[slot_reg] <= frame_in_reg;
        end
        frame_rd_reg <= frame_mem[slot_reg];
    end

    // Sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= lptt_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            lptt_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    state_next = lptt_pkg::S_LOOK;
                end
            end
            lptt_pkg::S_LOOK:
            begin
                state_next = lptt_pkg::S_LOCATE;
            end
            lptt_pkg::S_LOCATE:
            begin
                state_next = lptt_pkg::S_UPDATE;
            end
            lptt_pkg::S_UPDATE:
            begin
                if (out_free)
                begin
                    state_next = lptt_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = lptt_pkg::S_IDLE;
            end
        endcase
    end

    // Operation capture and per-step results
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            page_reg     <= in_virt[ADDR_W-1:OFS_W];
            offset_reg   <= in_virt[OFS_W-1:0];
            frame_in_reg <= in_phys[ADDR_W-1:OFS_W];
            key_reg      <= key_wide[PW-1:0];
            key_ok_reg   <= (key_wide >> PW) == '0;
        end
        if (state_reg == lptt_pkg::S_LOOK)
        begin
            found_reg <= look_found;
            slot_reg  <= look_slot;
        end
        if (state_reg == lptt_pkg::S_LOCATE)
        begin
            pos_reg <= ord_pos;
        end
    end

    // Opcode and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            func_reg <= lptt_pkg::FN_TRANSLATE;
            fill_reg <= '0;
        end
        else
        begin
            if (accept)
            begin
                func_reg <= in_func;
            end
            if (commit && map_fill)
            begin
                fill_reg <= fill_reg + CNT_W'(1);
            end
        end
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
        end
        else if (commit)
        begin
            m_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (commit)
        begin
            m_data_reg <= tr_hit ? {frame_rd_reg, offset_reg} : '0;
            m_user_reg <= {map_evict, tr_hit};
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;
    assign m_axis_tuser  = m_user_reg;

endmodule

/* sv/lptt_onehot_enc.sv */
// lptt_onehot_enc: one-hot to binary index encoder (OR tree).
// No dependencies.

module lptt_onehot_enc #(
    parameter int N = 64,
    parameter int W = 6
) (
    input  logic [N-1:0] onehot,
    output logic [W-1:0] idx
);

    // Each set bit ORs its own index in; at most one bit is set
    always_comb
    begin
        idx = '0;
        for (int i = 0; i < N; i++)
        begin
            if (onehot[i])
            begin
                idx = idx | W'(i);
            end
        end
    end

endmodule

/* sv/lptt_cam_cell.sv */
// lptt_cam_cell: one slot of the associative store: virtual page and mapped flag.
// Depends on lptt_pkg for the write control struct.

module lptt_cam_cell #(
    parameter int PW     = 36,
    parameter int SLOT_W = 6,
    parameter int IDX    = 0
) (
    input  logic              clk,
    input  logic              rst_n,
    input  lptt_pkg::cam_ctl_t ctl,
    input  logic [SLOT_W-1:0] slot,     // slot addressed by a write or clear
    input  logic [PW-1:0]     wr_page,
    input  logic [PW-1:0]     key,      // page being searched
    output logic              match
);

    logic          sel;
    logic [PW-1:0] page_reg;
    logic          mapped_reg;

    assign sel = (slot == SLOT_W'(IDX));

    // Page storage, written on fill or eviction
    always_ff @(posedge clk)
    begin
        if (ctl.write && sel)
        begin
            page_reg <= wr_page;
        end
    end

    // Mapped flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mapped_reg <= 1'b0;
        end
        else if (sel && ctl.write)
        begin
            mapped_reg <= 1'b1;
        end
        else if (sel && ctl.clear)
        begin
            mapped_reg <= 1'b0;
        end
    end

    assign match = mapped_reg && (page_reg == key);

endmodule

/* sv/lptt_order_cell.sv */
// lptt_order_cell: one position of the recency chain, holding a slot number.
// Shifts toward the least recent end by taking its neighbor's slot. Uses lptt_pkg.

module lptt_order_cell #(
    parameter int SLOT_W = 6,
    parameter int CNT_W  = 7,
    parameter int IDX    = 0
) (
    input  logic              clk,
    input  lptt_pkg::ord_ctl_t ctl,
    input  logic [CNT_W-1:0]  fill,     // positions in use
    input  logic [SLOT_W-1:0] pos,      // position the moved slot leaves
    input  logic [SLOT_W-1:0] slot,     // slot searched for, and slot loaded last
    input  logic [SLOT_W-1:0] next_id,  // slot held by the next position up
    output logic [SLOT_W-1:0] id,
    output logic              match
);

    logic [SLOT_W-1:0] id_reg;
    logic [SLOT_W-1:0] id_next;
    logic              in_use;
    logic              is_last;
    logic              is_free;

    assign in_use  = CNT_W'(IDX) < fill;
    assign is_last = (CNT_W'(IDX) + CNT_W'(1)) == fill;
    assign is_free = CNT_W'(IDX) == fill;

    // Move: positions from pos up to the last in use take their neighbor's slot,
    // the last in use takes the moved slot. Append: the first free one takes it.
    always_comb
    begin
        id_next = id_reg;
        if (ctl.move)
        begin
            if (is_last)
            begin
                id_next = slot;
            end
            else if (in_use && (SLOT_W'(IDX) >= pos))
            begin
                id_next = next_id;
            end
        end
        else if (ctl.append && is_free)
        begin
            id_next = slot;
        end
    end

    always_ff @(posedge clk)
    begin
        id_reg <= id_next;
    end

    assign id    = id_reg;
    assign match = in_use && (id_reg == slot);

endmodule
